[rtl/ple_pkg.sv]
package ple_pkg;

   // list geometry
   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // fixed field widths of the stream beats
   localparam int TYPE_W    = 3;
   localparam int POS_W     = 5;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // width that holds both a position and a count plus one
   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_INSERT_AT   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_DELETE_AT   = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_INSERT_LAST = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_DELETE_LAST = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ_ALL    = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic do_op;     // execute the accepted request, load its single result
      logic rd_start;  // begin streaming the list
      logic rd_step;   // load the next entry into the result register
   } ple_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // result register can take a beat this cycle
      logic empty;     // list holds no entry
      logic rd_last;   // read pointer sits on the tail entry
   } ple_sts_type;

endpackage

[rtl/ple_ctrl.sv]
module ple_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ple_pkg::TYPE_W-1:0]  req_kind,
   input  ple_pkg::ple_sts_type        sts,
   output ple_pkg::ple_cmd_type        cmd
);
   import ple_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // take a request only when idle and the result register has room
   assign req_tready = (state_ff == S_IDLE) && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.do_op    = 1'b0;
      cmd.rd_start = 1'b0;
      cmd.rd_step  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == REQ_READ_ALL && !sts.empty) begin
                  cmd.rd_start = 1'b1;
                  state_in     = S_READ;
               end else begin
                  cmd.do_op = 1'b1;
               end
            end
         end
         S_READ: begin
            if (sts.out_free) begin
               cmd.rd_step = 1'b1;
               if (sts.rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.do_op, cmd.rd_start, cmd.rd_step}))
      else $error("more than one datapath command");

   a_start_enters_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_start |=> (state_ff == S_READ))
      else $error("read start did not enter streaming");

   a_no_accept_reading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !req_tready)
      else $error("request accepted while streaming");

endmodule

[rtl/ple_datapath.sv]
module ple_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  ple_pkg::ple_cmd_type           cmd,
   output ple_pkg::ple_sts_type           sts,
   input  logic [ple_pkg::TYPE_W-1:0]     req_kind,
   input  logic [ple_pkg::POS_W-1:0]      position,
   input  logic signed [ple_pkg::VAL_W-1:0] value_in,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [ple_pkg::STAT_W-1:0]     status,
   output logic [ple_pkg::CNT_OUT_W-1:0]  count,
   output logic signed [ple_pkg::VAL_W-1:0] value_out,
   output logic                           value_valid,
   output logic                           last
);
   import ple_pkg::*;

   logic [DATA_WIDTH-1:0] cells_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] cells_in [CAPACITY];
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  rsp_valid_ff;
   logic [STAT_W-1:0]     rsp_status_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic [VAL_W-1:0]      rsp_value_ff;
   logic                  rsp_vvalid_ff;
   logic                  rsp_last_ff;

   logic [CMP_W-1:0]      pos_w;
   logic [CMP_W-1:0]      cnt_w;
   logic                  full;
   logic                  empty;
   logic                  ins_en;
   logic                  del_en;
   logic [IDX_W-1:0]      op_idx;
   logic [STAT_W-1:0]     op_status;
   logic [DATA_WIDTH-1:0] entry_val;

   assign pos_w     = CMP_W'(position);
   assign cnt_w     = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign entry_val = DATA_WIDTH'($unsigned(value_in));

   // decode the request against the current count
   always_comb begin
      op_status = STAT_OK;
      ins_en    = 1'b0;
      del_en    = 1'b0;
      op_idx    = '0;
      count_in  = count_ff;
      case (req_kind)
         REQ_INSERT_AT: begin
            if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
               op_status = STAT_BADPOS;
            end else if (full) begin
               op_status = STAT_FULL;
            end else begin
               ins_en   = 1'b1;
               op_idx   = IDX_W'(pos_w - CMP_W'(1));
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_DELETE_AT: begin
            if (pos_w == '0 || pos_w > cnt_w) begin
               op_status = STAT_BADPOS;
            end else begin
               del_en   = 1'b1;
               op_idx   = IDX_W'(pos_w - CMP_W'(1));
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_INSERT_LAST: begin
            if (full) begin
               op_status = STAT_FULL;
            end else begin
               ins_en   = 1'b1;
               op_idx   = IDX_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_DELETE_LAST: begin
            if (empty) begin
               op_status = STAT_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_READ_ALL: begin
            // only reaches here on an empty list
            op_status = STAT_EMPTY;
         end
         default: begin
            op_status = STAT_BADPOS;
         end
      endcase
   end

   // cell array: each cell picks the new value, itself, its lower or its upper neighbor
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int PREV = (g > 0) ? g - 1 : 0;
      localparam int NEXT = (g < CAPACITY - 1) ? g + 1 : g;
      assign cells_in[g] =
         (cmd.do_op && ins_en && IDX_W'(g) == op_idx) ? entry_val :
         (cmd.do_op && ins_en && IDX_W'(g) >  op_idx) ? cells_ff[PREV] :
         (cmd.do_op && del_en && IDX_W'(g) >= op_idx) ? cells_ff[NEXT] :
                                                        cells_ff[g];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.do_op) begin
         count_ff <= count_in;
      end
   end

   // read pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
      end else if (cmd.rd_start) begin
         rd_idx_ff <= '0;
      end else if (cmd.rd_step) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.do_op || cmd.rd_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cmd.do_op) begin
         rsp_status_ff <= op_status;
         rsp_count_ff  <= count_in;
         rsp_value_ff  <= '0;
         rsp_vvalid_ff <= 1'b0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.rd_step) begin
         rsp_status_ff <= STAT_OK;
         rsp_count_ff  <= count_ff;
         rsp_value_ff  <= VAL_W'(cells_ff[rd_idx_ff]);
         rsp_vvalid_ff <= 1'b1;
         rsp_last_ff   <= sts.rd_last;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.empty    = empty;
   assign sts.rd_last  = (CNT_W'(rd_idx_ff) + CNT_W'(1) == count_ff);

   assign rsp_valid   = rsp_valid_ff;
   assign status      = rsp_status_ff;
   assign count       = CNT_OUT_W'(rsp_count_ff);
   assign value_out   = rsp_value_ff;
   assign value_valid = rsp_vvalid_ff;
   assign last        = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_only_on_op: assert property (@(posedge clock) disable iff (reset)
      !cmd.do_op |=> $stable(count_ff))
      else $error("entry count moved without a request");

   a_tail_marks_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_step && sts.rd_last) |=> (rsp_last_ff && rsp_vvalid_ff))
      else $error("tail entry not marked last");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_step |-> (CNT_W'(rd_idx_ff) < count_ff))
      else $error("read pointer beyond list");

endmodule

[rtl/positional_list_engine.sv]
// Ordered list of up to 16 signed 32-bit values kept in a register cell
// array. A request other than a read of a non-empty list gives one result
// beat with last set; insert and delete shift every cell above the
// position as that request is taken. A read of a non-empty list takes a
// start step and then one beat per entry, in list order, loading the result
// register from one selected cell per cycle while it has room; its final
// beat carries last. The next request is taken once the previous request's
// beats have all been loaded and the result register has room. Bad
// positions, a full list and an empty list leave the list unchanged and
// report a status.
module positional_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] position, [36:5] value_in, [39:37] zero
   input  logic [39:0] req_tdata,
   // [2:0] req_type
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [6:2] count, [38:7] value_out, [39] value_valid
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);
   import ple_pkg::*;

   ple_cmd_type             cmd;
   ple_sts_type             sts;
   logic [STAT_W-1:0]       status;
   logic [CNT_OUT_W-1:0]    count;
   logic signed [VAL_W-1:0] value_out;
   logic                    value_valid;

   // sequencing
   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // cell array, count and result register
   ple_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_kind    (req_tuser),
      .position    (req_tdata[POS_W-1:0]),
      .value_in    (req_tdata[POS_W+VAL_W-1:POS_W]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .status      (status),
      .count       (count),
      .value_out   (value_out),
      .value_valid (value_valid),
      .last        (rsp_tlast)
   );

   // pack the result beat
   assign rsp_tdata = {value_valid, value_out, count, status};

endmodule
